@@ design/bvm_pkg.sv @@
package bvm_pkg;

  localparam int MEM_DEPTH     = 4096;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH   = 16;
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int XPOS_W        = $clog2(SCREEN_WIDTH);
  localparam int FONT_BASE     = 80;
  localparam int FONT_LEN      = 80;

  localparam logic [ADDR_W-1:0] PC_RST    = 12'd512;
  localparam logic [7:0]        TIMER_RST = 8'd60;

  // Configuration register indexes
  localparam logic CFG_PROG_START  = 1'b0;
  localparam logic CFG_TIMER_START = 1'b1;

  // Item kinds
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;

  // Instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] W_CLS = 16'h00E0;
  localparam logic [15:0] W_RET = 16'h00EE;

  // ALU group sub codes
  localparam logic [3:0] A_MOV = 4'h0;
  localparam logic [3:0] A_OR  = 4'h1;
  localparam logic [3:0] A_AND = 4'h2;
  localparam logic [3:0] A_XOR = 4'h3;
  localparam logic [3:0] A_ADD = 4'h4;
  localparam logic [3:0] A_SUB = 4'h5;
  localparam logic [3:0] A_SHR = 4'h6;
  localparam logic [3:0] A_SBN = 4'h7;
  localparam logic [3:0] A_SHL = 4'hE;

  // Key group and misc group sub codes
  localparam logic [7:0] K_SKP  = 8'h9E;
  localparam logic [7:0] K_SKNP = 8'hA1;
  localparam logic [7:0] F_GDT  = 8'h07;
  localparam logic [7:0] F_WKEY = 8'h0A;
  localparam logic [7:0] F_SDT  = 8'h15;
  localparam logic [7:0] F_SST  = 8'h18;
  localparam logic [7:0] F_ADDI = 8'h1E;
  localparam logic [7:0] F_FONT = 8'h29;
  localparam logic [7:0] F_BCD  = 8'h33;
  localparam logic [7:0] F_STR  = 8'h55;
  localparam logic [7:0] F_LDR  = 8'h65;

  typedef enum logic [2:0] {
    ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic                    clr;
    logic                    we;
    logic [ROW_W-1:0]        addr;
    logic [SCREEN_WIDTH-1:0] data;
  } fb_wr_t;

  localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Power-up content of one memory byte
  function automatic logic [7:0] mem_init_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    off = a - ADDR_W'(FONT_BASE);
    if (a >= ADDR_W'(FONT_BASE) && a < ADDR_W'(FONT_BASE + FONT_LEN)) begin
      return FONT_ROM[off[6:0]];
    end
    return 8'h00;
  endfunction

  // Split a byte into hundreds, tens, ones
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] r;
    logic [7:0] o;
    h = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
    r = v - ((h == 4'd2) ? 8'd200 : (h == 4'd1) ? 8'd100 : 8'd0);
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) t = 4'(k);
    end
    o = r - {t, 3'b000} - {3'b000, t, 1'b0};
    return {h, t, o[3:0]};
  endfunction

endpackage

@@ design/bytecode_vm_instruction_core.sv @@
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: address, byte, row,
//          |     |                              |   keys, random byte
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: pc, word, beep, wait, changed,
//          |     |                              |   unknown, row pixels
// cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A byte write, a row read and an instruction each step through their own states
// (sprite draw: row by row; register block store/load: register by register).
// Every memory access goes through the single port of the 4 KiB memory.
// After reset the memory is swept once; no item is taken meanwhile.
// One item is in flight at a time; the result waits in an output register.
module bytecode_vm_instruction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] mem_address, [19:12] mem_data, [24:20] row_select,
  // [40:25] keys_down, [48:41] random_byte, [55:49] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] program_counter, [27:12] executed_word, [28] beep,
  // [29] waiting_for_key, [30] screen_changed, [31] unknown_instruction,
  // [95:32] row_pixels
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import bvm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MW   = 5'd1;
  localparam logic [4:0] S_FIN  = 5'd2;
  localparam logic [4:0] S_ROW0 = 5'd3;
  localparam logic [4:0] S_ROW1 = 5'd4;
  localparam logic [4:0] S_F0   = 5'd5;
  localparam logic [4:0] S_F1   = 5'd6;
  localparam logic [4:0] S_F2   = 5'd7;
  localparam logic [4:0] S_RV   = 5'd8;
  localparam logic [4:0] S_EX   = 5'd9;
  localparam logic [4:0] S_VF   = 5'd10;
  localparam logic [4:0] S_D0   = 5'd11;
  localparam logic [4:0] S_D1   = 5'd12;
  localparam logic [4:0] S_DF   = 5'd13;
  localparam logic [4:0] S_B0   = 5'd14;
  localparam logic [4:0] S_B1   = 5'd15;
  localparam logic [4:0] S_B2   = 5'd16;
  localparam logic [4:0] S_S0   = 5'd17;
  localparam logic [4:0] S_S1   = 5'd18;
  localparam logic [4:0] S_L0   = 5'd19;
  localparam logic [4:0] S_L1   = 5'd20;
  localparam logic [4:0] S_TM   = 5'd21;

  logic [4:0]              state_q, state_d;
  logic [ADDR_W-1:0]       pc_q, pc_d;
  logic [ADDR_W-1:0]       i_q, i_d;
  logic [SP_W-1:0]         sp_q, sp_d;
  logic [7:0]              dt_q, dt_d;
  logic [7:0]              st_q, st_d;
  logic [7:0]              hi_q, hi_d;
  logic [15:0]             word_q, word_d;
  logic [3:0]              cnt_q, cnt_d;
  logic                    flag_q, flag_d;
  logic                    hit_q, hit_d;
  logic                    chg_q, chg_d;
  logic                    unk_q, unk_d;
  logic                    wait_q, wait_d;
  logic [7:0]              va_q, vb_q;
  logic [3:0]              va_addr, vb_addr;

  // Captured input item
  logic [1:0]              op_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [7:0]              data_q;
  logic [ROW_W-1:0]        row_q;
  logic [15:0]             keys_q;
  logic [7:0]              rnd_q;

  // Output register
  logic                    ov_q, ov_d;
  logic [ADDR_W-1:0]       opc_q, opc_d;
  logic [15:0]             oword_q, oword_d;
  logic                    obeep_q, obeep_d;
  logic                    owait_q, owait_d;
  logic                    ochg_q, ochg_d;
  logic                    ounk_q, ounk_d;
  logic [SCREEN_WIDTH-1:0] orow_q, orow_d;

  logic [7:0]              vreg_q [16];
  logic                    v_we;
  logic [3:0]              v_wa;
  logic [7:0]              v_wd;
  logic [ADDR_W-1:0]       stk_q [STACK_DEPTH];
  logic                    stk_we;

  mem_req_t                mreq;
  logic [7:0]              mem_rdata;
  logic                    mem_busy;
  fb_wr_t                  fbw;
  logic [ROW_W-1:0]        fb_raddr;
  logic [SCREEN_WIDTH-1:0] fb_rdata;
  logic                    fb_any;

  alu_op_e                 alu_op;
  logic [7:0]              alu_a, alu_b, alu_res;
  logic                    alu_flag, alu_eq;

  logic                    accept;
  logic [3:0]              w_x, w_y, w_n;
  logic [7:0]              w_nn;
  logic [ADDR_W-1:0]       w_nnn;
  logic [ADDR_W-1:0]       pcn;
  logic [ADDR_W-1:0]       i_off;
  logic [SP_W-1:0]         sp_inc, sp_dec;
  logic [5:0]              spr_row;
  logic [SCREEN_WIDTH-1:0] spr_mask;
  logic [11:0]             bcd;
  logic                    key_hit;
  logic [3:0]              first_key;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q && !mem_busy;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {orow_q, ounk_q, ochg_q, owait_q, obeep_q, oword_q, opc_q};

  assign w_x      = word_q[11:8];
  assign w_y      = word_q[7:4];
  assign w_n      = word_q[3:0];
  assign w_nn     = word_q[7:0];
  assign w_nnn    = word_q[11:0];
  assign pcn      = pc_q + ADDR_W'(2);
  assign i_off    = i_q + {{(ADDR_W-4){1'b0}}, cnt_q};
  assign sp_inc   = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec   = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign spr_row  = {1'b0, vb_q[ROW_W-1:0]} + {2'b00, cnt_q};
  assign spr_mask = {mem_rdata, {(SCREEN_WIDTH-8){1'b0}}} >> va_q[XPOS_W-1:0];
  assign bcd      = to_bcd(va_q);
  assign key_hit  = keys_q[va_q[3:0]];

  // Lowest pressed key
  always_comb begin
    first_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) first_key = 4'(k);
    end
  end

  bvm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  bvm_fb u_fb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fbw),
    .rd_addr_i (fb_raddr),
    .rd_data_o (fb_rdata),
    .any_set_o (fb_any)
  );

  bvm_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flag_o (alu_flag),
    .eq_o   (alu_eq)
  );

  // Register file read addresses
  always_comb begin
    va_addr = w_x;
    vb_addr = (word_q[15:12] == GRP_JPV0) ? 4'd0 : w_y;
    if (state_q == S_S0) va_addr = cnt_q;
  end

  // Memory port and frame buffer port selection
  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = pc_q;
    mreq.wdata = 8'h00;
    fb_raddr   = row_q;
    fbw.clr    = 1'b0;
    fbw.we     = 1'b0;
    fbw.addr   = spr_row[ROW_W-1:0];
    fbw.data   = fb_rdata ^ spr_mask;
    unique case (state_q)
      S_MW: begin
        mreq.we    = 1'b1;
        mreq.addr  = addr_q;
        mreq.wdata = data_q;
      end
      S_F1:   mreq.addr = pc_q + 1'b1;
      S_D0: begin
        mreq.addr = i_off;
        fb_raddr  = spr_row[ROW_W-1:0];
      end
      S_D1:   fbw.we = 1'b1;
      S_B0: begin
        mreq.we    = 1'b1;
        mreq.addr  = i_q;
        mreq.wdata = {4'h0, bcd[11:8]};
      end
      S_B1: begin
        mreq.we    = 1'b1;
        mreq.addr  = i_q + 1'b1;
        mreq.wdata = {4'h0, bcd[7:4]};
      end
      S_B2: begin
        mreq.we    = 1'b1;
        mreq.addr  = i_q + ADDR_W'(2);
        mreq.wdata = {4'h0, bcd[3:0]};
      end
      S_S1: begin
        mreq.we    = 1'b1;
        mreq.addr  = i_off;
        mreq.wdata = va_q;
      end
      S_L0:   mreq.addr = i_off;
      S_EX:   fbw.clr = (word_q == W_CLS);
      default: ;
    endcase
  end

  // Operand selection for the shared byte unit
  always_comb begin
    alu_op = ALU_PASS;
    alu_a  = va_q;
    alu_b  = vb_q;
    unique case (word_q[15:12])
      GRP_SEI, GRP_SNEI: alu_b = w_nn;
      GRP_ADDI: begin
        alu_op = ALU_ADD;
        alu_b  = w_nn;
      end
      GRP_RND: begin
        alu_op = ALU_AND;
        alu_a  = rnd_q;
        alu_b  = w_nn;
      end
      GRP_ALU: begin
        unique case (w_n)
          A_OR:  alu_op = ALU_OR;
          A_AND: alu_op = ALU_AND;
          A_XOR: alu_op = ALU_XOR;
          A_ADD: alu_op = ALU_ADD;
          A_SUB: alu_op = ALU_SUB;
          A_SHR: alu_op = ALU_SHR;
          A_SHL: alu_op = ALU_SHL;
          A_SBN: begin
            alu_op = ALU_SUB;
            alu_a  = vb_q;
            alu_b  = va_q;
          end
          default: alu_op = ALU_PASS;
        endcase
      end
      default: alu_op = ALU_PASS;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    i_d     = i_q;
    sp_d    = sp_q;
    dt_d    = dt_q;
    st_d    = st_q;
    hi_d    = hi_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    flag_d  = flag_q;
    hit_d   = hit_q;
    chg_d   = chg_q;
    unk_d   = unk_q;
    wait_d  = wait_q;
    v_we    = 1'b0;
    v_wa    = w_x;
    v_wd    = alu_res;
    stk_we  = 1'b0;
    ov_d    = ov_q && !m_axis_tready;
    opc_d   = opc_q;
    oword_d = oword_q;
    obeep_d = obeep_q;
    owait_d = owait_q;
    ochg_d  = ochg_q;
    ounk_d  = ounk_q;
    orow_d  = orow_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          chg_d  = 1'b0;
          unk_d  = 1'b0;
          wait_d = 1'b0;
          unique case (s_axis_tuser)
            OP_WRITE: state_d = S_MW;
            OP_RUN:   state_d = S_F0;
            OP_ROW:   state_d = S_ROW0;
            default:  state_d = S_FIN;
          endcase
        end
      end
      S_MW, S_FIN, S_ROW1: begin
        ov_d    = 1'b1;
        opc_d   = pc_q;
        oword_d = 16'h0000;
        obeep_d = 1'b0;
        owait_d = 1'b0;
        ochg_d  = 1'b0;
        ounk_d  = 1'b0;
        orow_d  = (state_q == S_ROW1) ? fb_rdata : '0;
        state_d = S_IDLE;
      end
      S_ROW0: state_d = S_ROW1;
      S_F0:   state_d = S_F1;
      S_F1: begin
        hi_d    = mem_rdata;
        state_d = S_F2;
      end
      S_F2: begin
        word_d  = {hi_q, mem_rdata};
        state_d = S_RV;
      end
      S_RV: state_d = S_EX;
      S_EX: begin
        pc_d    = pcn;
        state_d = S_TM;
        unique case (word_q[15:12])
          GRP_SYS: begin
            if (word_q == W_CLS) begin
              chg_d = fb_any;
            end else if (word_q == W_RET) begin
              sp_d = sp_dec;
              pc_d = stk_q[sp_dec];
            end else begin
              unk_d = 1'b1;
            end
          end
          GRP_JP: pc_d = w_nnn;
          GRP_CALL: begin
            stk_we = 1'b1;
            sp_d   = sp_inc;
            pc_d   = w_nnn;
          end
          GRP_SEI, GRP_SER: if (alu_eq) pc_d = pcn + ADDR_W'(2);
          GRP_SNEI, GRP_SNER: if (!alu_eq) pc_d = pcn + ADDR_W'(2);
          GRP_LDI: begin
            v_we = 1'b1;
            v_wd = w_nn;
          end
          GRP_ADDI, GRP_RND: v_we = 1'b1;
          GRP_ALU: begin
            unique case (w_n)
              A_MOV, A_OR, A_AND, A_XOR: v_we = 1'b1;
              A_ADD, A_SUB, A_SHR, A_SBN, A_SHL: begin
                v_we    = 1'b1;
                flag_d  = alu_flag;
                state_d = S_VF;
              end
              default: unk_d = 1'b1;
            endcase
          end
          GRP_LDIX: i_d = w_nnn;
          GRP_JPV0: pc_d = w_nnn + {{(ADDR_W-8){1'b0}}, vb_q};
          GRP_DRW: begin
            cnt_d   = 4'd0;
            hit_d   = 1'b0;
            state_d = (w_n == 4'd0) ? S_DF : S_D0;
          end
          GRP_KEY: begin
            if (w_nn == K_SKP) begin
              if (key_hit) pc_d = pcn + ADDR_W'(2);
            end else if (w_nn == K_SKNP) begin
              if (!key_hit) pc_d = pcn + ADDR_W'(2);
            end else begin
              unk_d = 1'b1;
            end
          end
          GRP_MISC: begin
            unique case (w_nn)
              F_GDT: begin
                v_we = 1'b1;
                v_wd = dt_q;
              end
              F_WKEY: begin
                if (|keys_q) begin
                  v_we = 1'b1;
                  v_wd = {4'h0, first_key};
                end else begin
                  pc_d   = pc_q;
                  wait_d = 1'b1;
                end
              end
              F_SDT:  dt_d = va_q;
              F_SST:  st_d = va_q;
              F_ADDI: i_d = i_q + {{(ADDR_W-8){1'b0}}, va_q};
              F_FONT: i_d = ADDR_W'(FONT_BASE)
                          + {{(ADDR_W-6){1'b0}}, va_q[3:0], 2'b00}
                          + {{(ADDR_W-4){1'b0}}, va_q[3:0]};
              F_BCD:  state_d = S_B0;
              F_STR: begin
                cnt_d   = 4'd0;
                state_d = S_S0;
              end
              F_LDR: begin
                cnt_d   = 4'd0;
                state_d = S_L0;
              end
              default: unk_d = 1'b1;
            endcase
          end
          default: unk_d = 1'b1;
        endcase
      end
      S_VF: begin
        v_we    = 1'b1;
        v_wa    = 4'hF;
        v_wd    = {7'd0, flag_q};
        state_d = S_TM;
      end
      S_D0: state_d = S_D1;
      S_D1: begin
        hit_d = hit_q | (|(fb_rdata & spr_mask));
        chg_d = chg_q | (|spr_mask);
        cnt_d = cnt_q + 1'b1;
        if ((cnt_q + 4'd1 == w_n) || (spr_row == 6'(SCREEN_HEIGHT - 1))) begin
          state_d = S_DF;
        end else begin
          state_d = S_D0;
        end
      end
      S_DF: begin
        v_we    = 1'b1;
        v_wa    = 4'hF;
        v_wd    = {7'd0, hit_q};
        state_d = S_TM;
      end
      S_B0: state_d = S_B1;
      S_B1: state_d = S_B2;
      S_B2: state_d = S_TM;
      S_S0: state_d = S_S1;
      S_S1: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = (cnt_q == w_x) ? S_TM : S_S0;
      end
      S_L0: state_d = S_L1;
      S_L1: begin
        v_we    = 1'b1;
        v_wa    = cnt_q;
        v_wd    = mem_rdata;
        cnt_d   = cnt_q + 1'b1;
        state_d = (cnt_q == w_x) ? S_TM : S_L0;
      end
      S_TM: begin
        dt_d    = (dt_q != 8'd0) ? dt_q - 1'b1 : 8'd0;
        st_d    = (st_q != 8'd0) ? st_q - 1'b1 : 8'd0;
        ov_d    = 1'b1;
        opc_d   = pc_q;
        oword_d = word_q;
        obeep_d = (st_q == 8'd1);
        owait_d = wait_q;
        ochg_d  = chg_q;
        ounk_d  = unk_q;
        orow_d  = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // Configuration writes load the live registers too
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PROG_START) begin
        pc_d = cfg_data_i;
      end else begin
        dt_d = cfg_data_i[7:0];
        st_d = cfg_data_i[7:0];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= PC_RST;
      i_q     <= '0;
      sp_q    <= '0;
      dt_q    <= TIMER_RST;
      st_q    <= TIMER_RST;
      ov_q    <= 1'b0;
      for (int r = 0; r < 16; r++) vreg_q[r] <= 8'h00;
      for (int r = 0; r < STACK_DEPTH; r++) stk_q[r] <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      i_q     <= i_d;
      sp_q    <= sp_d;
      dt_q    <= dt_d;
      st_q    <= st_d;
      ov_q    <= ov_d;
      if (v_we) vreg_q[v_wa] <= v_wd;
      if (stk_we) stk_q[sp_q] <= pcn;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    word_q  <= word_d;
    cnt_q   <= cnt_d;
    flag_q  <= flag_d;
    hit_q   <= hit_d;
    chg_q   <= chg_d;
    unk_q   <= unk_d;
    wait_q  <= wait_d;
    va_q    <= vreg_q[va_addr];
    vb_q    <= vreg_q[vb_addr];
    opc_q   <= opc_d;
    oword_q <= oword_d;
    obeep_q <= obeep_d;
    owait_q <= owait_d;
    ochg_q  <= ochg_d;
    ounk_q  <= ounk_d;
    orow_q  <= orow_d;
    if (accept) begin
      op_q   <= s_axis_tuser;
      addr_q <= s_axis_tdata[11:0];
      data_q <= s_axis_tdata[19:12];
      row_q  <= s_axis_tdata[24:20];
      keys_q <= s_axis_tdata[40:25];
      rnd_q  <= s_axis_tdata[48:41];
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE)) else $error("accepted item left sequencer idle");

  a_no_item_during_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !s_axis_tready) else $error("item taken during memory sweep");

  a_sprite_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D1) |-> !spr_row[5]) else $error("sprite row past bottom edge");

  a_flag_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VF) |-> ($past(state_q) == S_EX)) else $error("flag write out of order");

  a_row_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW0) |-> (op_q == OP_ROW)) else $error("row read for wrong kind");

endmodule

@@ design/bvm_alu.sv @@
module bvm_alu (
  input  bvm_pkg::alu_op_e op_i,
  input  logic [7:0]       a_i,
  input  logic [7:0]       b_i,
  output logic [7:0]       res_o,
  output logic             flag_o,
  output logic             eq_o
);
  import bvm_pkg::*;

  logic [8:0] sum;

  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign eq_o = (a_i == b_i);

  // Shared byte unit: logic, add, subtract, shifts
  always_comb begin
    res_o  = b_i;
    flag_o = 1'b0;
    unique case (op_i)
      ALU_PASS: res_o = b_i;
      ALU_OR:   res_o = a_i | b_i;
      ALU_AND:  res_o = a_i & b_i;
      ALU_XOR:  res_o = a_i ^ b_i;
      ALU_ADD: begin
        res_o  = sum[7:0];
        flag_o = sum[8];
      end
      ALU_SUB: begin
        res_o  = a_i - b_i;
        flag_o = (a_i >= b_i);
      end
      ALU_SHR: begin
        res_o  = {1'b0, a_i[7:1]};
        flag_o = a_i[0];
      end
      ALU_SHL: begin
        res_o  = {a_i[6:0], 1'b0};
        flag_o = a_i[7];
      end
      default: res_o = b_i;
    endcase
  end

endmodule

@@ design/bvm_mem.sv @@
module bvm_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bvm_pkg::mem_req_t             req_i,
  output logic [7:0]                    rdata_o,
  output logic                          busy_o
);
  import bvm_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [ADDR_W-1:0] init_cnt_q;
  logic              busy_q;

  assign busy_o = busy_q;

  // Sweep the whole memory once after reset: font at FONT_BASE, zeros elsewhere
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      busy_q     <= 1'b1;
    end else if (busy_q) begin
      init_cnt_q <= init_cnt_q + 1'b1;
      if (init_cnt_q == ADDR_W'(MEM_DEPTH - 1)) busy_q <= 1'b0;
    end
  end

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[init_cnt_q] <= mem_init_byte(init_cnt_q);
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

@@ design/bvm_fb.sv @@
module bvm_fb (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bvm_pkg::fb_wr_t                       wr_i,
  input  logic [bvm_pkg::ROW_W-1:0]             rd_addr_i,
  output logic [bvm_pkg::SCREEN_WIDTH-1:0]      rd_data_o,
  output logic                                  any_set_o
);
  import bvm_pkg::*;

  logic [SCREEN_WIDTH-1:0]  rows [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] valid_q;
  logic [SCREEN_HEIGHT-1:0] nz_q;
  logic [SCREEN_WIDTH-1:0]  rd_q;
  logic                     rd_vld_q;

  assign rd_data_o = rd_vld_q ? rd_q : '0;
  assign any_set_o = |nz_q;

  // Row valid and nonzero marks; a clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      nz_q     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[rd_addr_i];
      if (wr_i.clr) begin
        valid_q <= '0;
        nz_q    <= '0;
      end else if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
        nz_q[wr_i.addr]    <= |wr_i.data;
      end
    end
  end

  // Row storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) rows[wr_i.addr] <= wr_i.data;
    rd_q <= rows[rd_addr_i];
  end

endmodule
